[hdl/rmsn_pkg.sv]
package rmsn_pkg;

  // field and state widths
  localparam int unsigned LenW     = 13;
  localparam int unsigned EpsW     = 24;
  localparam int unsigned SumW     = 43;
  localparam int unsigned RmsW     = 29;
  localparam int unsigned NumW     = 57;
  localparam int unsigned DenW     = 44;
  localparam int unsigned RootInW  = 58;
  localparam int unsigned RemW     = 31;
  localparam int unsigned CntW     = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;

  // iteration counts of the shared divider and the root unit
  localparam int unsigned DivSteps  = 57;
  localparam int unsigned RootSteps = 29;

  // reset values of the configuration registers
  localparam int unsigned MaxLength = 4096;
  localparam logic [LenW-1:0] LEN_RESET = LenW'(MaxLength);
  localparam logic [EpsW-1:0] EPS_RESET = EpsW'(168);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LENGTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_EPSILON = 1'b1;

  // pass codes
  localparam logic FUNC_ACCUM = 1'b0;
  localparam logic FUNC_SCALE = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [15:0] sample;
    logic signed [15:0] gain;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               saturated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic acc;
    logic xg_load;
    logic mean_init;
    logic recip_init;
    logic r_max;
    logic div_step;
    logic root_init;
    logic root_step;
    logic root_store;
    logic prod_load;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ms_zero;
  } sts_t;

endpackage

[hdl/rms_normalize_vector_unit.sv]
// accumulate item: taken back to back, no result
// last accumulate item: block busy for two 57-step passes of the shared divider
//   and 29 root steps (only the first divider pass when the mean square is zero)
// scale item: sample times gain, times the factor, rounded result out, each registered;
//   the next item is taken as the result turns valid (later while a result stalls)
// async active-low reset: sum and factor cleared, length 4096, epsilon 168
module rms_normalize_vector_unit
  import rmsn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // configuration always taken
  assign cfg_ready_o = 1'b1;

  rmsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_last_i   (in_data_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmsn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/rmsn_ctrl.sv]
module rmsn_ctrl
  import rmsn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_func_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    IDLE,
    MEAN_LOAD,
    MEAN_DIV,
    RECIP_LOAD,
    RECIP_DIV,
    ROOT_LOAD,
    ROOT_STEP,
    ROOT_STORE,
    SCALE_MUL,
    SCALE_RND
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign accept   = (state_q == IDLE) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_ACCUM) begin
            cmd_o.acc = 1'b1;
            if (in_last_i) begin
              state_d = MEAN_LOAD;
            end
          end else begin
            cmd_o.xg_load = 1'b1;
            state_d       = SCALE_MUL;
          end
        end
      end
      MEAN_LOAD: begin
        cmd_o.mean_init = 1'b1;
        cnt_d           = '0;
        state_d         = MEAN_DIV;
      end
      MEAN_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = RECIP_LOAD;
        end
      end
      RECIP_LOAD: begin
        cnt_d = '0;
        if (sts_i.ms_zero) begin
          cmd_o.r_max = 1'b1;
          state_d     = IDLE;
        end else begin
          cmd_o.recip_init = 1'b1;
          state_d          = RECIP_DIV;
        end
      end
      RECIP_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ROOT_LOAD;
        end
      end
      ROOT_LOAD: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = ROOT_STEP;
      end
      ROOT_STEP: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootSteps - 1)) begin
          state_d = ROOT_STORE;
        end
      end
      ROOT_STORE: begin
        cmd_o.root_store = 1'b1;
        state_d          = IDLE;
      end
      SCALE_MUL: begin
        cmd_o.prod_load = 1'b1;
        state_d         = SCALE_RND;
      end
      SCALE_RND: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/rmsn_dp.sv]
module rmsn_dp
  import rmsn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_data_i,
  input  logic                cfg_write_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output out_item_t           out_data_o
);

  logic [LenW-1:0]    len_q;
  logic [EpsW-1:0]    eps_q;
  logic [SumW-1:0]    sum_q;
  logic [RmsW-1:0]    r_q;
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q;
  logic [DenW-1:0]    rem_q;
  logic [RootInW-1:0] sqv_q;
  logic [RemW-1:0]    srem_q;
  logic [RmsW-1:0]    root_q;
  logic signed [31:0] xg_q;
  logic signed [61:0] prod_q;
  out_item_t          out_q;

  logic signed [31:0] square;
  logic [SumW:0]      sum_add;
  logic [SumW-1:0]    sum_next;
  logic [LenW-1:0]    len_eff;
  logic [DenW-1:0]    ms;
  logic [DenW:0]      rem_sh;
  logic [DenW:0]      rem_diff;
  logic               q_bit;
  logic [RemW+1:0]    srem_sh;
  logic [RemW+1:0]    trial;
  logic [RemW+1:0]    srem_diff;
  logic               r_bit;
  logic signed [61:0] rounded;
  logic signed [33:0] y;
  out_item_t          out_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      eps_q <= EPS_RESET;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CFG_LENGTH:  len_q <= cfg_data_i[LenW-1:0];
        CFG_EPSILON: eps_q <= cfg_data_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // saturating sum of squares
  assign square   = in_data_i.sample * in_data_i.sample;
  assign sum_add  = {1'b0, sum_q} + (SumW+1)'(square[30:0]);
  assign sum_next = sum_add[SumW] ? '1 : sum_add[SumW-1:0];

  // mean square and zero-length guard
  assign len_eff = (len_q == '0) ? LenW'(1) : len_q;
  assign ms      = {1'b0, num_q[SumW-1:0]} + DenW'(eps_q);
  assign sts_o.ms_zero = (ms == '0);

  // restoring divider step, one quotient bit
  assign rem_sh   = {rem_q, num_q[NumW-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign q_bit    = (rem_sh >= {1'b0, den_q});

  // digit-by-digit square root step
  assign srem_sh   = {srem_q, sqv_q[RootInW-1 -: 2]};
  assign trial     = {2'b00, root_q, 2'b01};
  assign srem_diff = srem_sh - trial;
  assign r_bit     = (srem_sh >= trial);

  // running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.mean_init) begin
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_next;
    end
  end

  // stored factor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (cmd_i.r_max) begin
      r_q <= '1;
    end else if (cmd_i.root_store) begin
      r_q <= root_q;
    end
  end

  // shared divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_init) begin
      num_q <= NumW'(sum_q);
      den_q <= DenW'(len_eff);
      rem_q <= '0;
    end else if (cmd_i.recip_init) begin
      num_q <= NumW'(1) << (NumW - 1);
      den_q <= ms;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NumW-2:0], q_bit};
      rem_q <= q_bit ? rem_diff[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

  // root unit
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      sqv_q  <= RootInW'(num_q);
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      sqv_q  <= {sqv_q[RootInW-3:0], 2'b00};
      srem_q <= r_bit ? srem_diff[RemW-1:0] : srem_sh[RemW-1:0];
      root_q <= {root_q[RmsW-2:0], r_bit};
    end
  end

  // scale products, one multiplier per stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.xg_load) begin
      xg_q <= in_data_i.sample * in_data_i.gain;
    end
    if (cmd_i.prod_load) begin
      prod_q <= 62'(xg_q) * 62'($signed({1'b0, r_q}));
    end
  end

  // round half up, saturate
  assign rounded = prod_q + 62'sd134217728;
  assign y       = 34'(rounded >>> 28);

  always_comb begin
    out_d.result    = y[15:0];
    out_d.saturated = 1'b0;
    if (y > 34'sd32767) begin
      out_d.result    = 16'sh7fff;
      out_d.saturated = 1'b1;
    end else if (y < -34'sd32768) begin
      out_d.result    = 16'sh8000;
      out_d.saturated = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[hdl/rmsn_checker.sv]
module rmsn_checker
  import rmsn_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input in_item_t            in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_item_t           out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // plain accumulate transactions stream one per cycle
  a_acc_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.func == FUNC_ACCUM && !in_data_i.last |=> in_ready_o)
    else $error("accumulate transaction stalled the input");

  // last accumulate transaction starts the factor update
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.func == FUNC_ACCUM && in_data_i.last |=> !in_ready_o)
    else $error("input taken during factor update");

  // accumulate transactions create no result
  a_acc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.func == FUNC_ACCUM |=> !$rose(out_valid_o))
    else $error("result from accumulate transaction");

  // one scale transaction in flight
  a_scale_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.func == FUNC_SCALE |=> !in_ready_o)
    else $error("second scale transaction taken early");

endmodule

bind rms_normalize_vector_unit rmsn_checker u_checker (.*);

[dv/tb_rms_normalize_vector_unit.sv]
module tb_rms_normalize_vector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rmsn_pkg::*;

  localparam longint unsigned SumLimit = (64'd1 << SumW) - 64'd1;
  localparam int unsigned ItemTarget = 1500;
  localparam int unsigned SettleCycles = 200;

  // mirror of the normalizer: running square sum, factor and registers
  class rms_scoreboard;
    logic [LenW-1:0] length;
    logic [EpsW-1:0] eps;
    logic [SumW-1:0] sum_sq;
    logic [RmsW-1:0] inv_rms;
    out_item_t       scaled_q[$];
    int unsigned     errors;

    function new();
      length  = LEN_RESET;
      eps     = EPS_RESET;
      sum_sq  = '0;
      inv_rms = '0;
      errors  = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_LENGTH) begin
        length = val[LenW-1:0];
      end else if (idx == CFG_EPSILON) begin
        eps = val[EpsW-1:0];
      end
    endfunction

    // accumulate updates the sum and factor, scale predicts one result
    function void note_input(in_item_t it);
      longint signed   xs;
      longint signed   gs;
      longint signed   rs;
      longint signed   prod;
      longint signed   y;
      longint unsigned total;
      longint unsigned divisor;
      longint unsigned mean_sq;
      longint unsigned quot;
      longint unsigned root;
      longint unsigned cand;
      out_item_t       exp_item;
      xs = it.sample;
      gs = it.gain;
      if (it.func == FUNC_ACCUM) begin
        total = 64'(sum_sq) + 64'(xs * xs);
        if (total > SumLimit) begin
          total = SumLimit;
        end
        sum_sq = total[SumW-1:0];
        if (it.last) begin
          // zero length divides as one
          divisor = (length == '0) ? 64'd1 : 64'(length);
          mean_sq = 64'(sum_sq) / divisor + 64'(eps);
          if (mean_sq == 0) begin
            inv_rms = '1;
          end else begin
            quot = (64'd1 << 56) / mean_sq;
            root = 0;
            for (int b = RmsW - 1; b >= 0; b--) begin
              cand = root | (64'd1 << b);
              if (cand * cand <= quot) begin
                root = cand;
              end
            end
            inv_rms = root[RmsW-1:0];
          end
          sum_sq = '0;
        end
      end else begin
        rs = 64'(inv_rms);
        prod = xs * gs * rs;
        y = (prod + (longint'(1) <<< 27)) >>> 28;
        exp_item.saturated = 1'b0;
        if (y > 32767) begin
          y = 32767;
          exp_item.saturated = 1'b1;
        end else if (y < -32768) begin
          y = -32768;
          exp_item.saturated = 1'b1;
        end
        exp_item.result = y[15:0];
        scaled_q.push_back(exp_item);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (scaled_q.size() == 0) begin
        errors++;
        $error("unexpected result transaction: result %0d saturated %0b",
               got.result, got.saturated);
        return;
      end
      exp_item = scaled_q.pop_front();
      if (got.result !== exp_item.result) begin
        errors++;
        $error("result: expected %0d actual %0d", exp_item.result, got.result);
      end
      if (got.saturated !== exp_item.saturated) begin
        errors++;
        $error("saturated: expected %0b actual %0b", exp_item.saturated, got.saturated);
      end
    endfunction

    function int unsigned pending();
      return scaled_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  rms_scoreboard sb = new();
  int unsigned   in_gap_max = 8;
  int unsigned   out_gap_max = 8;
  int unsigned   items_sent = 0;

  rms_normalize_vector_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // one input transaction; valid stays high across back-to-back items
  task automatic send_item(logic func, logic [15:0] sample, logic [15:0] gain, logic last);
    int unsigned gap;
    in_item_t    it;
    gap = $urandom_range(0, in_gap_max);
    it.func   = func;
    it.sample = sample;
    it.gain   = gain;
    it.last   = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for every result, then let a factor update finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // accumulate pass of n elements, magnitude reduced by shift
  task automatic send_vector(int unsigned n, int unsigned shift);
    logic signed [15:0] v;
    for (int unsigned k = 0; k < n; k++) begin
      v = 16'($urandom);
      v = v >>> shift;
      send_item(FUNC_ACCUM, v, 16'($urandom), k == n - 1);
    end
  endtask

  // scale pass with full-range gains and a stray last now and then
  task automatic send_scales(int unsigned m);
    logic signed [15:0] v;
    for (int unsigned k = 0; k < m; k++) begin
      v = 16'($urandom);
      v = v >>> $urandom_range(0, 15);
      send_item(FUNC_SCALE, v, 16'($urandom), 1'($urandom));
    end
  endtask

  // result side: random stall before each result transaction
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
    end
  end

  // stimulus
  initial begin
    logic [LenW-1:0] len;
    logic [EpsW-1:0] eps;
    int unsigned     n;
    int unsigned     vectors;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // scale before any accumulate uses the zero factor, stray last included
    send_item(FUNC_SCALE, 16'h7fff, 16'h7fff, 1'b1);
    send_item(FUNC_SCALE, 16'h8000, 16'h8000, 1'b0);
    settle();

    // zero mean square saturates the factor
    write_reg(CFG_LENGTH, 24'd1);
    write_reg(CFG_EPSILON, 24'd0);
    send_item(FUNC_ACCUM, 16'h0000, 16'hffff, 1'b1);
    send_item(FUNC_SCALE, 16'h0001, 16'h0001, 1'b0);
    send_item(FUNC_SCALE, 16'h8000, 16'h7fff, 1'b1);
    send_item(FUNC_SCALE, 16'h8000, 16'h8000, 1'b0);
    send_item(FUNC_SCALE, 16'h0000, 16'h8000, 1'b0);
    send_item(FUNC_SCALE, 16'h7fff, 16'h0001, 1'b0);
    settle();

    // zero length divides as one, largest epsilon
    write_reg(CFG_LENGTH, 24'd0);
    write_reg(CFG_EPSILON, 24'hffffff);
    send_item(FUNC_ACCUM, 16'h7fff, 16'h0000, 1'b0);
    send_item(FUNC_ACCUM, 16'h8000, 16'h7fff, 1'b1);
    send_item(FUNC_SCALE, 16'h7fff, 16'h7fff, 1'b0);
    send_item(FUNC_SCALE, 16'h8000, 16'h0001, 1'b1);
    send_item(FUNC_SCALE, 16'hffff, 16'hffff, 1'b0);
    settle();

    // long vector of full-scale samples at the reset length 4096, no idling
    in_gap_max  = 0;
    out_gap_max = 0;
    write_reg(CFG_LENGTH, 24'(MaxLength));
    write_reg(CFG_EPSILON, 24'(EPS_RESET));
    for (int unsigned k = 0; k < 256; k++) begin
      send_item(FUNC_ACCUM, 16'h8000, 16'h0000, k == 255);
    end
    send_item(FUNC_SCALE, 16'h7fff, 16'h7fff, 1'b0);
    send_item(FUNC_SCALE, 16'h8000, 16'h7fff, 1'b0);
    send_item(FUNC_SCALE, 16'h1000, 16'h1000, 1'b0);
    settle();

    // random phases, each with its own register setting and idling
    n = ItemTarget;
    while (items_sent < n) begin
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = LenW'(1);
        2:       len = LenW'(MaxLength);
        3:       len = '1;
        4:       len = LenW'($urandom);
        default: len = LenW'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       eps = '0;
        1:       eps = '1;
        2:       eps = EPS_RESET;
        3:       eps = EpsW'($urandom);
        default: eps = EpsW'($urandom_range(0, 255));
      endcase
      write_reg(CFG_LENGTH, {11'($urandom), len});
      write_reg(CFG_EPSILON, eps);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      vectors = $urandom_range(1, 6);
      for (int unsigned v = 0; v < vectors; v++) begin
        if ($urandom_range(0, 99) < 85) begin
          if (len >= 1 && len <= 32) begin
            send_vector(32'(len), $urandom_range(0, 15));
            send_scales($urandom_range(1, int'(len) + 2));
          end else begin
            send_vector($urandom_range(1, 32), $urandom_range(0, 15));
            send_scales($urandom_range(1, 34));
          end
        end else begin
          // noise: any mix of passes and last flags
          repeat ($urandom_range(1, 12)) begin
            send_item(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
          end
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
hdl/rmsn_pkg.sv
hdl/rmsn_ctrl.sv
hdl/rmsn_dp.sv
hdl/rms_normalize_vector_unit.sv
hdl/rmsn_checker.sv
dv/tb_rms_normalize_vector_unit.sv
